/* hdl/explorative_bucket_priority_queue_top_macros.svh */
// assertion macros for the bucket priority queue
// used by explorative_bucket_priority_queue_top, needs clk and rst_n in scope
`ifndef EXPLORATIVE_BUCKET_PRIORITY_QUEUE_TOP_MACROS_SVH
`define EXPLORATIVE_BUCKET_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define EBPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebpq assertion failed");

// next-cycle implication
`define EBPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebpq assertion failed");

`endif

/* hdl/ebpq_pkg.sv */
// types, codes and helpers for the bucket priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ebpq_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_CLEAR3 = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [CNT_W-1:0] LIMIT_RESET = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_RD,
        S_INS_WR,
        S_REM_SCAN_MIN,
        S_REM_RD_HT,
        S_REM_RD_SLOT,
        S_REM_WR,
        S_REM_SCAN_NEXT,
        S_REM_SCAN_BACK,
        S_FIN
    } state_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        cnt_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* hdl/explorative_bucket_priority_queue_top.sv */
// bucket priority queue with fifo order per key, top level
// depends on ebpq_pkg and explorative_bucket_priority_queue_top_macros.svh
// slot, link and bucket pointer memories live here, occupancy in flip-flops
`timescale 1ns / 1ps
`default_nettype none
`include "explorative_bucket_priority_queue_top_macros.svh"

// Commands are taken when start is high and busy is low; each command gives
// exactly one result beat, shown for one cycle with done high, and the
// receiver cannot stall it. The occupancy map is scanned one key per cycle.
// Clear, full insert and empty remove go straight to the result. An insert
// first scans for the smallest occupied key. A remove scans above its key for
// the next occupied key, plus a scan from key 0 when its bucket is empty and
// a rescan from key 0 when the cursor returns to the minimum.
// No clearing pass after reset: slots are handed out by a fill count.
module explorative_bucket_priority_queue_top
    import ebpq_pkg::*;
#(
    parameter int KEY_VALUES   = 256,
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              opcode,
    input  wire logic [7:0]              priority_key,
    input  wire logic [PAYLOAD_BITS-1:0] payload,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [PAYLOAD_BITS-1:0]      removed_payload,
    output logic [7:0]                   removed_key,
    output logic [10:0]                  entry_count,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CNT_W-1:0]        cfg_data
);

    localparam int KW = (KEY_VALUES > 1) ? $clog2(KEY_VALUES) : 1;
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [KW-1:0]           key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [KW-1:0]           cur_reg, cur_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        lim_reg, lim_next;
    logic [CW-1:0]           total_reg, total_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [SW-1:0]           fhead_reg, fhead_next;
    logic [KEY_VALUES-1:0]   occ_reg, occ_next;
    logic [KW:0]             scan_reg, scan_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic                    last_reg, last_next;
    logic                    done_reg, done_next;
    logic [2:0]              rstat_reg, rstat_next;
    logic [PAYLOAD_BITS-1:0] rpay_reg, rpay_next;
    logic [KW-1:0]           rkey_reg, rkey_next;
    logic [CW-1:0]           rcnt_reg, rcnt_next;

    logic [PAYLOAD_BITS-1:0] entry_mem [CAPACITY];
    logic [SW-1:0]           link_mem  [CAPACITY];
    logic [SW-1:0]           head_mem  [KEY_VALUES];
    logic [SW-1:0]           tail_mem  [KEY_VALUES];

    logic [PAYLOAD_BITS-1:0] entry_rd;
    logic [SW-1:0]           link_rd, head_rd, tail_rd;
    logic [SW-1:0]           link_ra;
    logic                    entry_we, link_we, head_we, tail_we;
    logic [SW-1:0]           entry_wa, link_wa, link_wd, head_wd, tail_wd;

    logic                    accept;
    logic                    scan_end, scan_hit;
    logic [KW-1:0]           scan_key;
    logic                    recycled, lim_on;
    logic [CNT_W-1:0]        cnt_one;
    logic [KW-1:0]           key_sat;
    logic [SW-1:0]           new_slot;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign done            = done_reg;
    assign status          = rstat_reg;
    assign removed_payload = rpay_reg;
    assign removed_key     = 8'(rkey_reg);
    assign entry_count     = 11'(rcnt_reg);

    assign scan_end = (scan_reg >= (KW+1)'(KEY_VALUES));
    assign scan_key = scan_reg[KW-1:0];
    assign scan_hit = !scan_end && occ_reg[scan_key];
    assign recycled = (fill_reg != total_reg);
    assign lim_on   = !lim_reg[CNT_W-1];
    assign cnt_one  = cnt_inc(cnt_reg);
    assign new_slot = recycled ? fhead_reg : fill_reg[SW-1:0];
    assign key_sat  = ({9'd0, priority_key} >= 17'(KEY_VALUES)) ? KW'(KEY_VALUES - 1)
                                                               : KW'(priority_key);
    assign link_ra  = (state_reg == S_REM_RD_SLOT) ? head_rd : fhead_reg;

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_wa] <= pay_reg;
        end
        entry_rd <= entry_mem[head_rd];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[key_reg] <= head_wd;
        end
        head_rd <= head_mem[key_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[key_reg] <= tail_wd;
        end
        tail_rd <= tail_mem[key_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            cnt_reg   <= '0;
            lim_reg   <= LIMIT_RESET;
            total_reg <= '0;
            fill_reg  <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
            total_reg <= total_next;
            fill_reg  <= fill_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        pay_reg   <= pay_next;
        fhead_reg <= fhead_next;
        scan_reg  <= scan_next;
        slot_reg  <= slot_next;
        last_reg  <= last_next;
        rstat_reg <= rstat_next;
        rpay_reg  <= rpay_next;
        rkey_reg  <= rkey_next;
        rcnt_reg  <= rcnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        lim_next   = lim_reg;
        total_next = total_reg;
        fill_next  = fill_reg;
        fhead_next = fhead_reg;
        occ_next   = occ_reg;
        scan_next  = scan_reg;
        slot_next  = slot_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        rstat_next = rstat_reg;
        rpay_next  = rpay_reg;
        rkey_next  = rkey_reg;
        rcnt_next  = rcnt_reg;
        entry_we   = 1'b0;
        link_we    = 1'b0;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        entry_wa   = new_slot;
        link_wa    = tail_rd;
        link_wd    = new_slot;
        head_wd    = new_slot;
        tail_wd    = new_slot;

        if (cfg_valid)
        begin
            lim_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pay_next  = payload;
                    rpay_next = '0;
                    rkey_next = '0;
                    scan_next = '0;
                    case (opcode)
                        OP_INSERT:
                        begin
                            key_next = key_sat;
                            if (total_reg >= CW'(CAPACITY))
                            begin
                                rstat_next = ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                rstat_next = ST_INSERTED;
                                state_next = S_INS_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            key_next = cur_reg;
                            if (total_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                rstat_next = ST_REMOVED;
                                state_next = occ_reg[cur_reg] ? S_REM_RD_HT : S_REM_SCAN_MIN;
                            end
                        end
                        default:
                        begin
                            occ_next   = '0;
                            total_next = '0;
                            fill_next  = '0;
                            rstat_next = ST_CLEARED;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_SCAN:
            begin
                if (scan_hit || scan_end)
                begin
                    if (scan_end || (key_reg < scan_key))
                    begin
                        cur_next = key_reg;
                        cnt_next = '0;
                    end
                    state_next = S_INS_RD;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                entry_we = 1'b1;
                if (occ_reg[key_reg])
                begin
                    link_we = 1'b1;
                end
                else
                begin
                    head_we = 1'b1;
                end
                tail_we = 1'b1;
                occ_next[key_reg] = 1'b1;
                total_next = total_reg + 1'b1;
                if (recycled)
                begin
                    fhead_next = link_rd;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_FIN;
            end
            S_REM_SCAN_MIN:
            begin
                if (scan_hit)
                begin
                    key_next   = scan_key;
                    cur_next   = scan_key;
                    cnt_next   = '0;
                    state_next = S_REM_RD_HT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_REM_RD_HT:
            begin
                state_next = S_REM_RD_SLOT;
            end
            S_REM_RD_SLOT:
            begin
                slot_next  = head_rd;
                last_next  = (head_rd == tail_rd);
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                rpay_next = entry_rd;
                rkey_next = key_reg;
                if (last_reg)
                begin
                    occ_next[key_reg] = 1'b0;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wd = link_rd;
                end
                link_we    = 1'b1;
                link_wa    = slot_reg;
                link_wd    = fhead_reg;
                fhead_next = slot_reg;
                total_next = total_reg - 1'b1;
                scan_next  = {1'b0, key_reg} + 1'b1;
                state_next = S_REM_SCAN_NEXT;
            end
            S_REM_SCAN_NEXT:
            begin
                if (scan_hit)
                begin
                    if (lim_on && (cnt_one > {1'b0, lim_reg[CNT_W-2:0]}))
                    begin
                        cnt_next   = '0;
                        scan_next  = '0;
                        state_next = S_REM_SCAN_BACK;
                    end
                    else
                    begin
                        cnt_next   = lim_on ? cnt_inc(cnt_one) : cnt_one;
                        cur_next   = scan_key;
                        state_next = S_FIN;
                    end
                end
                else if (scan_end)
                begin
                    cnt_next   = '0;
                    scan_next  = '0;
                    state_next = S_REM_SCAN_BACK;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_REM_SCAN_BACK:
            begin
                if (scan_hit)
                begin
                    cur_next   = scan_key;
                    state_next = S_FIN;
                end
                else if (scan_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                rcnt_next  = total_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `EBPQ_ASSERT_NEXT(a_done_single, done, !done)
    `EBPQ_ASSERT_NEXT(a_accept_busy, accept, busy)
    `EBPQ_ASSERT_NOW(a_total_cap, 1'b1, total_reg <= CW'(CAPACITY))
    `EBPQ_ASSERT_NOW(a_fill_total, 1'b1, fill_reg >= total_reg)
    `EBPQ_ASSERT_NOW(a_empty_map, total_reg == '0, occ_reg == '0)

endmodule

`default_nettype wire

/* tb/explorative_bucket_priority_queue_top_tb.sv */
// testbench for the bucket priority queue with fifo order per key
// depends on ebpq_pkg and explorative_bucket_priority_queue_top; predicts every result beat
`timescale 1ns / 1ps
`default_nettype none

module explorative_bucket_priority_queue_top_tb
    import ebpq_pkg::*;
();

    localparam int KEYS = 256;
    localparam int CAP = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int RING = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rpay;
        logic [7:0]  rkey;
        logic [10:0] count;
    } beat_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] opcode;
    logic [7:0] priority_key;
    logic [31:0] payload;
    logic done;
    logic [2:0] status;
    logic [31:0] removed_payload;
    logic [7:0] removed_key;
    logic [10:0] entry_count;
    logic cfg_valid;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // queue model: one ring per key
    logic [31:0] fifo_data [KEYS][CAP];
    int fifo_rd [KEYS];
    int fifo_cnt [KEYS];
    int unsigned total;
    logic [7:0] cursor;
    logic [16:0] explore_cnt;
    bit limit_on;
    logic [15:0] limit_val;

    beat_t beat_ring [RING];
    int unsigned beat_wr;
    int unsigned beat_rd;
    int errors;
    int idle_cycles;

    explorative_bucket_priority_queue_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .priority_key(priority_key), .payload(payload),
        .done(done), .status(status), .removed_payload(removed_payload),
        .removed_key(removed_key), .entry_count(entry_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void fifo_put(int k, logic [31:0] d);
        fifo_data[k][(fifo_rd[k] + fifo_cnt[k]) % CAP] = d;
        fifo_cnt[k]++;
    endfunction

    function automatic logic [31:0] fifo_take(int k);
        logic [31:0] d;
        d = fifo_data[k][fifo_rd[k]];
        fifo_rd[k] = (fifo_rd[k] + 1) % CAP;
        fifo_cnt[k]--;
        return d;
    endfunction

    function automatic void fifo_reset();
        for (int i = 0; i < KEYS; i++)
        begin
            fifo_rd[i] = 0;
            fifo_cnt[i] = 0;
        end
    endfunction

    function automatic int next_key(int from);
        for (int k = from; k < KEYS; k++)
            if (fifo_cnt[k] != 0)
                return k;
        return -1;
    endfunction

    function automatic int min_key();
        return next_key(0);
    endfunction

    function automatic logic [16:0] sat_inc(logic [16:0] c);
        return (c == 17'h1FFFF) ? c : c + 17'd1;
    endfunction

    function automatic beat_t predict_queue(logic [1:0] op, logic [7:0] key, logic [31:0] data);
        beat_t b;
        int mk;
        int k;
        int nk;
        bit back;
        b = '0;
        if (op == OP_INSERT)
        begin
            if (total >= CAP)
                b.status = ST_FULL;
            else
            begin
                mk = min_key();
                if (mk < 0 || int'(key) < mk)
                begin
                    cursor = key;
                    explore_cnt = '0;
                end
                fifo_put(int'(key), data);
                total++;
                b.status = ST_INSERTED;
            end
        end
        else if (op == OP_REMOVE)
        begin
            mk = min_key();
            if (total == 0 || mk < 0)
                b.status = ST_EMPTY;
            else
            begin
                k = int'(cursor);
                if (fifo_cnt[k] == 0)
                begin
                    k = mk;
                    cursor = 8'(k);
                    explore_cnt = '0;
                end
                b.rpay = fifo_take(k);
                b.rkey = 8'(k);
                total--;
                nk = (k + 1 < KEYS) ? next_key(k + 1) : -1;
                back = (nk < 0);
                if (!back && limit_on)
                begin
                    explore_cnt = sat_inc(explore_cnt);
                    back = explore_cnt > {1'b0, limit_val};
                end
                if (back)
                begin
                    explore_cnt = '0;
                    mk = min_key();
                    if (mk >= 0)
                        cursor = 8'(mk);
                end
                else
                begin
                    explore_cnt = sat_inc(explore_cnt);
                    cursor = 8'(nk);
                end
                b.status = ST_REMOVED;
            end
        end
        else
        begin
            fifo_reset();
            total = 0;
            b.status = ST_CLEARED;
        end
        b.count = 11'(total);
        return b;
    endfunction

    task automatic send_cmd(logic [1:0] op, logic [7:0] key, logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 6);
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        opcode <= op;
        priority_key <= key;
        payload <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beat_ring[beat_wr % RING] = predict_queue(op, key, data);
        beat_wr++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (beat_wr != beat_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [16:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limit_on = (v[16] == 1'b0);
        limit_val = v[15:0];
    endtask

    always @(posedge clk)
    begin : check_beat
        beat_t want;
        if (done)
        begin
            if (beat_wr == beat_rd)
            begin
                $display("%0t unexpected beat: expected none actual st %0d pay %h key %0d cnt %0d",
                    $time, status, removed_payload, removed_key, entry_count);
                errors++;
            end
            else
            begin
                want = beat_ring[beat_rd % RING];
                beat_rd++;
                if (status !== want.status || removed_payload !== want.rpay ||
                    removed_key !== want.rkey || entry_count !== want.count)
                begin
                    $display("%0t mismatch: expected st %0d pay %h key %0d cnt %0d", $time,
                        want.status, want.rpay, want.rkey, want.count);
                    $display("%0t           actual   st %0d pay %h key %0d cnt %0d", $time,
                        status, removed_payload, removed_key, entry_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(OP_REMOVE, 8'd0, 32'h0);
        send_cmd(OP_INSERT, 8'd255, 32'hFFFFFFFF);
        send_cmd(OP_INSERT, 8'd0, 32'h00000000);
        send_cmd(OP_INSERT, 8'd0, 32'hA5A5A5A5);
        send_cmd(OP_INSERT, 8'd17, 32'h5A5A5A5A);
        send_cmd(OP_INSERT, 8'd128, 32'h12345678);
        repeat (6) send_cmd(OP_REMOVE, 8'hFF, 32'hFFFFFFFF);
        send_cmd(OP_INSERT, 8'd9, 32'h1);
        send_cmd(OP_CLEAR, 8'd0, 32'h0);
        send_cmd(OP_REMOVE, 8'd0, 32'h0);
        send_cmd(OP_INSERT, 8'd3, 32'h2);
        send_cmd(OP_CLEAR3, 8'd0, 32'h0);
        send_cmd(OP_REMOVE, 8'd0, 32'h0);
    endtask

    task automatic test_full();
        for (int i = 0; i < CAP + 2; i++)
            send_cmd(OP_INSERT, 8'($urandom_range(0, 7)), $urandom);
        for (int i = 0; i < 20; i++)
            send_cmd(OP_REMOVE, 8'($urandom), $urandom);
        send_cmd(OP_CLEAR, 8'd0, 32'h0);
    endtask

    task automatic test_random(int n);
        logic [1:0] op;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 52) ? OP_INSERT : (r < 97) ? OP_REMOVE : (r < 99) ? OP_CLEAR : OP_CLEAR3;
            if ($urandom_range(0, 3) == 0)
                send_cmd(op, 8'($urandom), $urandom);
            else
                send_cmd(op, 8'($urandom_range(0, 24)), $urandom);
        end
    endtask

    task automatic test_limit(logic [16:0] v, int n);
        write_limit(v);
        test_random(n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = '0;
        priority_key = '0;
        payload = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        beat_wr = 0;
        beat_rd = 0;
        total = 0;
        cursor = '0;
        explore_cnt = '0;
        limit_on = 1'b0;
        limit_val = '0;
        fifo_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100);
        test_limit(17'd0, 80);
        test_limit(17'd1, 80);
        test_limit(17'd3, 80);
        test_limit(17'h0FFFF, 80);
        write_limit(17'h1FFFF);
        test_full();
        test_limit(17'd2, 100);
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/ebpq_pkg.sv
hdl/explorative_bucket_priority_queue_top.sv
tb/explorative_bucket_priority_queue_top_tb.sv
